[src/sac_pkg.sv]
// Shared types, tables and nibble functions for the simplified AES cipher.
// No dependencies; used by every other file of the block.
`default_nettype none

package sac_pkg;

    typedef logic [3:0]  nibble_t;
    typedef logic [15:0] block_t;

    typedef struct packed {
        block_t k0;
        block_t k1;
        block_t k2;
    } round_keys_t;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    localparam logic [7:0] RCON1 = 8'h80;
    localparam logic [7:0] RCON2 = 8'h30;

    // x^4 + x + 1, applied once the product spills into bit 4
    localparam logic [4:0] GF_POLY = 5'h13;

    localparam nibble_t MIX_FWD_D = 4'h1;
    localparam nibble_t MIX_FWD_O = 4'h4;
    localparam nibble_t MIX_INV_D = 4'h9;
    localparam nibble_t MIX_INV_O = 4'h2;

    localparam nibble_t SBOX_FWD [16] = '{
        4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
        4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
    };

    localparam nibble_t SBOX_INV [16] = '{
        4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
        4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
    };

    function automatic nibble_t gf16_mul(input nibble_t a, input nibble_t b);
        nibble_t    acc;
        logic [4:0] aa;
        acc = '0;
        aa  = {1'b0, a};
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ aa[3:0];
            end
            aa = {aa[3:0], 1'b0};
            if (aa[4])
            begin
                aa = aa ^ GF_POLY;
            end
        end
        return acc;
    endfunction

    function automatic block_t sub_nib(input block_t s, input logic inv);
        block_t r;
        for (int i = 0; i < 4; i++)
        begin
            r[i*4 +: 4] = inv ? SBOX_INV[s[i*4 +: 4]] : SBOX_FWD[s[i*4 +: 4]];
        end
        return r;
    endfunction

    // nibbles n0..n3 (MSB first) become n0, n3, n2, n1
    function automatic block_t shift_row(input block_t s);
        return {s[15:12], s[3:0], s[7:4], s[11:8]};
    endfunction

    function automatic block_t mix_cols(input block_t s, input nibble_t d,
                                        input nibble_t o);
        nibble_t n0, n1, n2, n3;
        n0 = s[15:12];
        n1 = s[11:8];
        n2 = s[7:4];
        n3 = s[3:0];
        return {gf16_mul(d, n0) ^ gf16_mul(o, n1),
                gf16_mul(o, n0) ^ gf16_mul(d, n1),
                gf16_mul(d, n2) ^ gf16_mul(o, n3),
                gf16_mul(o, n2) ^ gf16_mul(d, n3)};
    endfunction

    function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
        logic [7:0] w0, w1, w2, w3, t;
        w0 = k[15:8];
        w1 = k[7:0];
        t  = {SBOX_FWD[w1[3:0]], SBOX_FWD[w1[7:4]]};
        w2 = w0 ^ rc ^ t;
        w3 = w2 ^ w1;
        return {w2, w3};
    endfunction

endpackage

`default_nettype wire

[src/simplified_aes_cipher_top.sv]
// Top level of the simplified AES cipher: input register, rounds, result register.
// Depends on sac_pkg, sac_key_expand and sac_rounds.
//
//   channel  | handshake      | payload
//   ---------+----------------+-------------------------------------------
//   input    | start / busy   | operation, data_block, cipher_key
//   result   | done (strobe)  | result_block
//
// An item taken into the input register passes the rounds into the result register, which drives done.
// One item is accepted every cycle; busy stays low, as nothing is shared.
// Reset clears the valid flags only; the payload registers hold no reset value.
// done lasts one cycle and the receiver has no way to hold it off.
`default_nettype none

module simplified_aes_cipher_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         operation,
    input  wire  [15:0] data_block,
    input  wire  [15:0] cipher_key,
    output logic        done,
    output logic [15:0] result_block
);

    logic                 in_valid_reg;
    logic                 op_reg;
    sac_pkg::block_t      data_reg;
    sac_pkg::block_t      key_reg;
    logic                 out_valid_reg;
    sac_pkg::block_t      result_reg;

    sac_pkg::round_keys_t round_keys;
    sac_pkg::block_t      result_next;
    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= accept;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            data_reg <= data_block;
            key_reg  <= cipher_key;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    sac_key_expand u_key_expand (
        .cipher_key (key_reg),
        .round_keys (round_keys)
    );

    sac_rounds u_rounds (
        .operation    (sac_pkg::op_t'(op_reg)),
        .data_block   (data_reg),
        .round_keys   (round_keys),
        .result_block (result_next)
    );

    assign done         = out_valid_reg;
    assign result_block = result_reg;

endmodule

`default_nettype wire

[src/sac_key_expand.sv]
// Key schedule: expands the 16-bit cipher key into round keys K0, K1, K2.
// Depends on sac_pkg.
`default_nettype none

module sac_key_expand (
    input  wire sac_pkg::block_t      cipher_key,
    output sac_pkg::round_keys_t      round_keys
);

    sac_pkg::block_t k1;

    assign k1 = sac_pkg::next_round_key(cipher_key, sac_pkg::RCON1);

    always_comb
    begin
        round_keys.k0 = cipher_key;
        round_keys.k1 = k1;
        round_keys.k2 = sac_pkg::next_round_key(k1, sac_pkg::RCON2);
    end

endmodule

`default_nettype wire

[src/sac_rounds.sv]
// Both cipher rounds for encryption and decryption, purely combinational.
// Depends on sac_pkg; round keys come from sac_key_expand.
`default_nettype none

module sac_rounds (
    input  wire sac_pkg::op_t         operation,
    input  wire sac_pkg::block_t      data_block,
    input  wire sac_pkg::round_keys_t round_keys,
    output sac_pkg::block_t           result_block
);

    sac_pkg::block_t enc, dec;

    always_comb
    begin
        enc = data_block ^ round_keys.k0;
        enc = sac_pkg::shift_row(sac_pkg::sub_nib(enc, 1'b0));
        enc = sac_pkg::mix_cols(enc, sac_pkg::MIX_FWD_D, sac_pkg::MIX_FWD_O);
        enc = enc ^ round_keys.k1;
        enc = sac_pkg::shift_row(sac_pkg::sub_nib(enc, 1'b0));
        enc = enc ^ round_keys.k2;
    end

    always_comb
    begin
        dec = data_block ^ round_keys.k2;
        dec = sac_pkg::sub_nib(sac_pkg::shift_row(dec), 1'b1);
        dec = dec ^ round_keys.k1;
        dec = sac_pkg::mix_cols(dec, sac_pkg::MIX_INV_D, sac_pkg::MIX_INV_O);
        dec = sac_pkg::sub_nib(sac_pkg::shift_row(dec), 1'b1);
        dec = dec ^ round_keys.k0;
    end

    always_comb
    begin
        case (operation)
            sac_pkg::OP_ENCRYPT: result_block = enc;
            sac_pkg::OP_DECRYPT: result_block = dec;
            default:             result_block = enc;
        endcase
    end

endmodule

`default_nettype wire

[tb/simplified_aes_cipher_top_tb.sv]
// Self-checking testbench for simplified_aes_cipher_top: two-round S-AES on 16-bit blocks.
// Depends on sac_pkg for the block, nibble and operation types and the round constants.
`default_nettype none

module simplified_aes_cipher_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int GAP_PERCENT  = 32;

    // Keeps the expected blocks in order and predicts each one from its item.
    class saes_scoreboard;
        sac_pkg::block_t expected_blocks[$];
        int     error_count;
        int     checked_count;
        int     encrypt_count;
        int     decrypt_count;

        function new();
            error_count   = 0;
            checked_count = 0;
            encrypt_count = 0;
            decrypt_count = 0;
        endfunction

        function sac_pkg::nibble_t fwd_sub(input sac_pkg::nibble_t n);
            logic [63:0] tab;
            tab = 64'h94AB_D185_6203_CEF7;
            return tab[(15 - n) * 4 +: 4];
        endfunction

        function sac_pkg::nibble_t inv_sub(input sac_pkg::nibble_t n);
            logic [63:0] tab;
            tab = 64'hA59B_178F_6023_C4DE;
            return tab[(15 - n) * 4 +: 4];
        endfunction

        // multiply in GF(16), reducing by x^4+x+1
        function sac_pkg::nibble_t gf16_product(input sac_pkg::nibble_t a,
                                                input sac_pkg::nibble_t b);
            logic [4:0]        shifted;
            sac_pkg::nibble_t  acc;
            acc     = '0;
            shifted = {1'b0, a};
            for (int i = 0; i < 4; i++)
            begin
                if (b[i])
                begin
                    acc ^= shifted[3:0];
                end
                shifted = {shifted[3:0], 1'b0};
                if (shifted[4])
                begin
                    shifted ^= 5'h13;
                end
            end
            return acc;
        endfunction

        function sac_pkg::block_t substitute(input sac_pkg::block_t s, input sac_pkg::op_t op);
            sac_pkg::block_t r;
            for (int i = 0; i < 4; i++)
            begin
                r[i*4 +: 4] = (op == sac_pkg::OP_DECRYPT) ? inv_sub(s[i*4 +: 4])
                                                          : fwd_sub(s[i*4 +: 4]);
            end
            return r;
        endfunction

        // second row of the 2x2 state swaps its two nibbles
        function sac_pkg::block_t swap_low_row(input sac_pkg::block_t s);
            return {s[15:12], s[3:0], s[7:4], s[11:8]};
        endfunction

        function sac_pkg::block_t mix_columns(input sac_pkg::block_t s,
                                              input sac_pkg::nibble_t d,
                                              input sac_pkg::nibble_t o);
            return {gf16_product(d, s[15:12]) ^ gf16_product(o, s[11:8]),
                    gf16_product(o, s[15:12]) ^ gf16_product(d, s[11:8]),
                    gf16_product(d, s[7:4])   ^ gf16_product(o, s[3:0]),
                    gf16_product(o, s[7:4])   ^ gf16_product(d, s[3:0])};
        endfunction

        function sac_pkg::block_t expand_key(input sac_pkg::block_t k, input logic [7:0] rc);
            logic [7:0] hi_word, lo_word, rotated, next_hi;
            hi_word = k[15:8];
            lo_word = k[7:0];
            rotated = {fwd_sub(lo_word[3:0]), fwd_sub(lo_word[7:4])};
            next_hi = hi_word ^ rc ^ rotated;
            return {next_hi, next_hi ^ lo_word};
        endfunction

        function sac_pkg::block_t cipher_block(input sac_pkg::op_t op,
                                               input sac_pkg::block_t data,
                                               input sac_pkg::block_t key);
            sac_pkg::block_t k1, k2, s;
            k1 = expand_key(key, sac_pkg::RCON1);
            k2 = expand_key(k1, sac_pkg::RCON2);
            if (op == sac_pkg::OP_ENCRYPT)
            begin
                s = data ^ key;
                s = mix_columns(swap_low_row(substitute(s, sac_pkg::OP_ENCRYPT)), 4'h1, 4'h4)
                    ^ k1;
                s = swap_low_row(substitute(s, sac_pkg::OP_ENCRYPT)) ^ k2;
            end
            else
            begin
                s = data ^ k2;
                s = substitute(swap_low_row(s), sac_pkg::OP_DECRYPT) ^ k1;
                s = substitute(swap_low_row(mix_columns(s, 4'h9, 4'h2)), sac_pkg::OP_DECRYPT)
                    ^ key;
            end
            return s;
        endfunction

        function void note_item(input sac_pkg::op_t op, input sac_pkg::block_t data,
                                input sac_pkg::block_t key);
            expected_blocks.insert(expected_blocks.size(), cipher_block(op, data, key));
            if (op == sac_pkg::OP_ENCRYPT)
            begin
                encrypt_count++;
            end
            else
            begin
                decrypt_count++;
            end
        endfunction

        function void check_result(input sac_pkg::block_t actual, input realtime stamp);
            sac_pkg::block_t predicted;
            if (expected_blocks.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got %h", stamp, actual);
                error_count++;
                return;
            end
            predicted = expected_blocks.pop_front();
            checked_count++;
            if (actual !== predicted)
            begin
                $display("%0t ns: result_block mismatch, expected %h, got %h",
                         stamp, predicted, actual);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        operation;
    logic [15:0] data_block;
    logic [15:0] cipher_key;
    wire         busy;
    wire         done;
    wire  [15:0] result_block;

    saes_scoreboard sb = new();

    simplified_aes_cipher_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .data_block   (data_block),
        .cipher_key   (cipher_key),
        .done         (done),
        .result_block (result_block)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // results first: a result at this edge belongs to an earlier item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result(result_block, $realtime);
            end
            if (start && !busy)
            begin
                sb.note_item(sac_pkg::op_t'(operation), data_block, cipher_key);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simplified_aes_cipher_top_tb: errors");
        $finish;
    end

    task automatic send_item(input sac_pkg::op_t op, input sac_pkg::block_t data,
                             input sac_pkg::block_t key, input bit with_gaps);
        while (with_gaps && $urandom_range(99) < GAP_PERCENT)
        begin
            @(negedge clk);
            start      <= 1'b0;
            operation  <= 1'($urandom_range(1));
            data_block <= 16'($urandom_range(16'hFFFF));
            cipher_key <= 16'($urandom_range(16'hFFFF));
        end
        @(negedge clk);
        start      <= 1'b1;
        operation  <= op;
        data_block <= data;
        cipher_key <= key;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // encrypt, then decrypt the predicted ciphertext with the same key
    task automatic send_round_trip(input sac_pkg::block_t data, input sac_pkg::block_t key,
                                   input bit with_gaps);
        sac_pkg::block_t ciphertext;
        ciphertext = sb.cipher_block(sac_pkg::OP_ENCRYPT, data, key);
        send_item(sac_pkg::OP_ENCRYPT, data, key, with_gaps);
        send_item(sac_pkg::OP_DECRYPT, ciphertext, key, with_gaps);
    endtask

    function automatic sac_pkg::block_t pick_block();
        sac_pkg::block_t v;
        case ($urandom_range(7))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'h0001 << $urandom_range(15);
            3: v = ~(16'h0001 << $urandom_range(15));
            default: v = 16'($urandom_range(16'hFFFF));
        endcase
        return v;
    endfunction

    initial
    begin
        bit            with_gaps;
        sac_pkg::op_t  op;
        int     mode;
        int     sent;
        int     drain;

        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = 1'b0;
        data_block = '0;
        cipher_key = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, both operations, known vector, round trips
        for (int o = 0; o < 2; o++)
        begin
            op = sac_pkg::op_t'(o);
            send_item(op, 16'h0000, 16'h0000, 1'b0);
            send_item(op, 16'hFFFF, 16'hFFFF, 1'b0);
            send_item(op, 16'h0000, 16'hFFFF, 1'b1);
            send_item(op, 16'hFFFF, 16'h0000, 1'b1);
            send_item(op, 16'h5555, 16'hAAAA, 1'b0);
            send_item(op, 16'hAAAA, 16'h5555, 1'b1);
        end
        send_item(sac_pkg::OP_ENCRYPT, 16'h6F6B, 16'hA73B, 1'b0);
        send_item(sac_pkg::OP_DECRYPT, 16'h0738, 16'hA73B, 1'b0);
        send_round_trip(16'h8001, 16'h1248, 1'b1);
        send_round_trip(16'h7FFE, 16'hEDB7, 1'b0);
        send_item(sac_pkg::OP_ENCRYPT, 16'h1234, 16'h8421, 1'b1);
        send_item(sac_pkg::OP_DECRYPT, 16'hFEDC, 16'h7BDE, 1'b1);

        // random; a stretch in the middle runs back to back
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            with_gaps = !(sent >= 700 && sent < 1000);
            mode      = $urandom_range(9);
            if (mode < 3)
            begin
                send_round_trip(pick_block(), pick_block(), with_gaps);
                sent += 2;
            end
            else
            begin
                send_item(sac_pkg::op_t'($urandom_range(1)), pick_block(), pick_block(),
                          with_gaps);
                sent++;
            end
        end
        @(negedge clk);
        start <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        drain = DRAIN_CYCLES;
        repeat (drain) @(posedge clk);

        $display("Covered %0d encrypt and %0d decrypt items, %0d results checked.",
                 sb.encrypt_count, sb.decrypt_count, sb.checked_count);
        $display("Directed extremes, a known vector and round trips, then random blocks and keys.");
        if (sb.error_count == 0 && sb.pending() == 0)
        begin
            $display("simplified_aes_cipher_top_tb: clean");
        end
        else
        begin
            $display("simplified_aes_cipher_top_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
